// ----- design/osrg_pkg.sv -----
// Shared types and constants for the ordered set rank and gap query block.
package osrg_pkg;

  // Default number of cells in the sorted chain.
  localparam int DefCapacity = 1024;

  // Widths of the fixed transaction fields.
  localparam int ValueW  = 32;
  localparam int RankW   = 10;
  localparam int AnswerW = 33;

  // Request codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GAP    = 2'd2,
    OP_SPAN   = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RANK = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_CMP,
    CMD_INS,
    CMD_DEL,
    CMD_ROT
  } cell_cmd_e;

  // Control state of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_SCAN
  } state_e;

  // Broadcast bundle from the controller to the cells.
  typedef struct packed {
    cell_cmd_e           cmd;
    logic [ValueW-1:0]   value;
  } cell_ctrl_t;

endpackage

// ----- design/osrg_cell.sv -----
// One cell of the sorted chain: holds one value and shifts with its neighbors.
module osrg_cell (
  input  logic                      clk_i,
  input  osrg_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      occupied_i,
  input  logic [osrg_pkg::ValueW-1:0] prev_val_i,
  input  logic                      prev_lt_i,
  input  logic [osrg_pkg::ValueW-1:0] next_val_i,
  output logic [osrg_pkg::ValueW-1:0] val_o,
  output logic                      lt_o,
  output logic                      eq_o
);
  import osrg_pkg::*;

  logic [ValueW-1:0] val_q;
  logic              lt_q;
  logic              eq_q;

  // Compare flags are taken once per update and steer the following shift.
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.cmd)
      CMD_CMP: begin
        lt_q <= occupied_i && ($signed(val_q) < $signed(ctrl_i.value));
        eq_q <= occupied_i && (val_q == ctrl_i.value);
      end
      CMD_INS: begin
        if (!lt_q) begin
          val_q <= prev_lt_i ? ctrl_i.value : prev_val_i;
        end
      end
      CMD_DEL: begin
        if (!lt_q) begin
          val_q <= next_val_i;
        end
      end
      CMD_ROT: begin
        val_q <= prev_val_i;
      end
      default: begin
      end
    endcase
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

// ----- design/ordered_set_rank_gap_queries.sv -----
// Top level: sorted chain of cells with insert, delete, gap and span queries.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o opcode, value, first_rank, last_rank
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i answer, status
//
// Insert and delete run as accept, compare in every cell, then a one-place shift
// when the set changes. A gap or span query with distinct, valid ranks rotates the
// whole chain once through the tail cell; other gap and span queries answer on accept.
// Reset clears the control state and the count; cell contents are not reset.
// One transaction is in work at a time; a new one is taken once the result
// register is empty, so a stalled output holds the input side.
module ordered_set_rank_gap_queries #(
  parameter int CAPACITY = osrg_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // opcode[1:0], value[33:2], first_rank[43:34], last_rank[53:44], zero[55:54]
  input  logic [55:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // answer[32:0], status[34:33], zero[39:35]
  output logic [39:0] m_axis_tdata_o
);
  import osrg_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = (CW > RankW) ? CW : RankW;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
  localparam logic [IW-1:0] LastIdx  = IW'(CAPACITY - 1);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     rank_q, rank_d;
  op_e               op_q, op_d;
  logic [ValueW-1:0] value_q, value_d;
  logic [RankW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [ValueW-1:0] prev_q, prev_d, best_q, best_d;
  logic [ValueW-1:0] lov_q, lov_d, hiv_q, hiv_d;
  logic              ovalid_q, ovalid_d;
  logic [AnswerW-1:0] ans_q, ans_d;
  status_e           stat_q, stat_d;
  cell_ctrl_t        ctrl;

  logic [ValueW-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0] lts, eqs, occ;

  op_e              in_op;
  logic [RankW-1:0] in_a, in_b;
  logic             in_acc;
  logic             found;
  logic [ValueW-1:0] cur, gap, best_n, lov_n, hiv_n;
  logic [RW-1:0]    rank_x, lo_x, hi_x;
  logic             in_rng;

  assign in_op  = op_e'(s_axis_tdata_i[1:0]);
  assign in_a   = s_axis_tdata_i[43:34];
  assign in_b   = s_axis_tdata_i[53:44];
  assign s_axis_tready_o = (state_q == S_IDLE) && !ovalid_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign found  = |eqs;

  // Chain of cells; cell 0 takes the tail value while rotating.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CW'(i) < count_q);
    osrg_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occupied_i (occ[i]),
      .prev_val_i ((i == 0) ? vals[CAPACITY-1] : vals[(i == 0) ? 0 : i-1]),
      .prev_lt_i  ((i == 0) ? 1'b1 : lts[(i == 0) ? 0 : i-1]),
      .next_val_i ((i == CAPACITY-1) ? vals[i] : vals[(i == CAPACITY-1) ? i : i+1]),
      .val_o      (vals[i]),
      .lt_o       (lts[i]),
      .eq_o       (eqs[i])
    );
  end

  // Scan datapath: ranks leave the tail in descending order.
  assign cur    = vals[CAPACITY-1];
  assign gap    = prev_q - cur;
  assign rank_x = RW'(rank_q);
  assign lo_x   = RW'(lo_q);
  assign hi_x   = RW'(hi_q);
  assign in_rng = (rank_x >= lo_x) && (rank_x < hi_x);
  assign best_n = (in_rng && (gap < best_q)) ? gap : best_q;
  assign lov_n  = (rank_x == lo_x) ? cur : lov_q;
  assign hiv_n  = (rank_x == hi_x) ? cur : hiv_q;

  // Next state, cell commands and result register.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rank_d   = rank_q;
    op_d     = op_q;
    value_d  = value_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    prev_d   = prev_q;
    best_d   = best_q;
    lov_d    = lov_q;
    hiv_d    = hiv_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    ans_d    = ans_q;
    stat_d   = stat_q;
    ctrl.cmd   = CMD_HOLD;
    ctrl.value = value_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d    = in_op;
          value_d = s_axis_tdata_i[33:2];
          lo_d    = (in_a < in_b) ? in_a : in_b;
          hi_d    = (in_a < in_b) ? in_b : in_a;
          if (in_op == OP_INSERT || in_op == OP_DELETE) begin
            state_d = S_CMP;
          end else if (in_a == in_b) begin
            ovalid_d = 1'b1;
            ans_d    = '1;
            stat_d   = ST_OK;
          end else if (RW'((in_a < in_b) ? in_b : in_a) >= RW'(count_q)) begin
            ovalid_d = 1'b1;
            ans_d    = '0;
            stat_d   = ST_RANK;
          end else begin
            state_d = S_SCAN;
            rank_d  = LastIdx;
            best_d  = '1;
          end
        end
      end
      S_CMP: begin
        ctrl.cmd = CMD_CMP;
        state_d  = S_UPD;
      end
      S_UPD: begin
        state_d = S_IDLE;
        if (op_q == OP_INSERT) begin
          if (!found) begin
            if (count_q >= CapCount) begin
              ovalid_d = 1'b1;
              ans_d    = '0;
              stat_d   = ST_FULL;
            end else begin
              ctrl.cmd = CMD_INS;
              count_d  = count_q + CW'(1);
            end
          end
        end else if (found) begin
          ctrl.cmd = CMD_DEL;
          count_d  = count_q - CW'(1);
        end
      end
      S_SCAN: begin
        ctrl.cmd = CMD_ROT;
        prev_d   = cur;
        best_d   = best_n;
        lov_d    = lov_n;
        hiv_d    = hiv_n;
        rank_d   = rank_q - IW'(1);
        if (rank_q == '0) begin
          state_d  = S_IDLE;
          ovalid_d = 1'b1;
          stat_d   = ST_OK;
          ans_d    = (op_q == OP_SPAN) ? {1'b0, hiv_n - lov_n} : {1'b0, best_n};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rank_q  <= rank_d;
    op_q    <= op_d;
    value_q <= value_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    prev_q  <= prev_d;
    best_q  <= best_d;
    lov_q   <= lov_d;
    hiv_q   <= hiv_d;
    ans_q   <= ans_d;
    stat_q  <= stat_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'b0, stat_q, ans_q};

  // The count never passes the table size.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount) else $error("count above capacity");

  // A scan always ends in a result.
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rank_q == '0) |=> m_axis_tvalid_o)
    else $error("scan ended without result");

  // Count changes only from the update step.
  a_count_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_UPD) |=> $stable(count_q)) else $error("stray count change");

endmodule
